// ===== rtl/dtt_pkg.sv =====
// Shared types, sizes and codes for the deadline timer table.
package dtt_pkg;

    // Table size and derived index widths
    localparam int MAX_TIMERS = 16;
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

    // Input word modes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // Result word kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // Result id sources
    localparam logic [1:0] ID_ZERO  = 2'd0;
    localparam logic [1:0] ID_NEW   = 2'd1;
    localparam logic [1:0] ID_ENTRY = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] now;
        logic [31:0] period_ms;
        logic [31:0] timer_id;
        logic        repeat_req;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] result_id;
        logic        last;
    } t_out_word;

    // One table entry as held in the entry memory
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] interval;
        logic [31:0] deadline;
        logic        rpt;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic       rd;
        logic       inc_i;
        logic       add_exec;
        logic       clear_exec;
        logic       rm_hit;
        logic       tick_step;
        logic       tick_end;
        logic       emit;
        logic [1:0] emit_kind;
        logic       emit_last;
        logic [1:0] id_sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic scan_end;
        logic id_zero;
        logic id_hit;
        logic due;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/dtt_ctrl.sv =====
// Sequencer for add, remove, clear and tick operations of the timer table.
module dtt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_in_mode,
    input  dtt_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output dtt_pkg::t_cmd  o_cmd
);
    import dtt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD     = 4'd1;
    localparam logic [3:0] S_CLEAR   = 4'd2;
    localparam logic [3:0] S_RM_RD   = 4'd3;
    localparam logic [3:0] S_RM_EV   = 4'd4;
    localparam logic [3:0] S_ACK     = 4'd5;
    localparam logic [3:0] S_TK_RD   = 4'd6;
    localparam logic [3:0] S_TK_EV   = 4'd7;
    localparam logic [3:0] S_TK_DONE = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_cmd      = cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    case (i_in_mode)
                        MODE_ADD:    n_state = S_ADD;
                        MODE_REMOVE: n_state = S_RM_RD;
                        MODE_CLEAR:  n_state = S_CLEAR;
                        default:     n_state = S_TK_RD;
                    endcase
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    cmd.add_exec  = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ACK;
                    cmd.emit_last = 1'b1;
                    cmd.id_sel    = ID_NEW;
                    n_state       = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_stat.out_free) begin
                    cmd.clear_exec = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_kind  = KIND_ACK;
                    cmd.emit_last  = 1'b1;
                    cmd.id_sel     = ID_ZERO;
                    n_state        = S_IDLE;
                end
            end
            S_RM_RD: begin
                if (i_stat.id_zero || i_stat.scan_end) begin
                    n_state = S_ACK;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_RM_EV;
                end
            end
            S_RM_EV: begin
                // Cancel the first entry holding the id, active or not
                if (i_stat.id_hit) begin
                    cmd.rm_hit = 1'b1;
                    n_state    = S_ACK;
                end else begin
                    cmd.inc_i = 1'b1;
                    n_state   = S_RM_RD;
                end
            end
            S_ACK: begin
                if (i_stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_ACK;
                    cmd.emit_last = 1'b1;
                    cmd.id_sel    = ID_ZERO;
                    n_state       = S_IDLE;
                end
            end
            S_TK_RD: begin
                if (i_stat.scan_end) begin
                    n_state = S_TK_DONE;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_TK_EV;
                end
            end
            S_TK_EV: begin
                // Hold a due entry until the output register can take its word
                if (!i_stat.due || i_stat.out_free) begin
                    cmd.tick_step = 1'b1;
                    cmd.emit      = i_stat.due;
                    cmd.emit_kind = KIND_FIRED;
                    cmd.emit_last = 1'b0;
                    cmd.id_sel    = ID_ENTRY;
                    n_state       = S_TK_RD;
                end
            end
            S_TK_DONE: begin
                if (i_stat.out_free) begin
                    cmd.tick_end  = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = KIND_DONE;
                    cmd.emit_last = 1'b1;
                    cmd.id_sel    = ID_ZERO;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/dtt_datapath.sv =====
// Entry memory, active bits, counters, scan pointers and output register.
module dtt_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dtt_pkg::t_in_word  i_in_word,
    input  dtt_pkg::t_cmd      i_cmd,
    input  logic               i_out_stall,
    output dtt_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output dtt_pkg::t_out_word o_out_word
);
    import dtt_pkg::*;

    t_entry                  r_mem [MAX_TIMERS];
    t_entry                  r_rd_data;
    logic                    r_rd_act;
    t_in_word                r_in;
    logic [MAX_TIMERS-1:0]   r_active;
    logic [CNT_W-1:0]        r_count;
    logic [31:0]             r_id_ctr;
    logic [CNT_W-1:0]        r_i;
    logic [CNT_W-1:0]        r_w;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    logic        full;
    logic        out_free;
    logic [31:0] diff;
    logic        due;
    logic        keep;
    logic [31:0] new_deadline;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_entry      wr_data;
    logic [31:0] sel_id;

    // Status of the current entry and the table
    assign full         = (r_count >= CNT_W'(MAX_TIMERS));
    assign out_free     = !r_out_valid || !i_out_stall;
    assign diff         = r_in.now - r_rd_data.deadline;
    assign due          = r_rd_act && !diff[31];
    assign keep         = r_rd_act && (!due || r_rd_data.rpt);
    assign new_deadline = (due && r_rd_data.rpt) ? r_rd_data.deadline + r_rd_data.interval
                                                 : r_rd_data.deadline;

    assign o_stat.scan_end = (r_i == r_count);
    assign o_stat.id_zero  = (r_in.timer_id == 32'd0);
    assign o_stat.id_hit   = (r_rd_data.id == r_in.timer_id);
    assign o_stat.due      = due;
    assign o_stat.out_free = out_free;

    // Select the memory write: append on add, compact on tick
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_w[IDX_W-1:0];
        wr_data = '{id: r_rd_data.id, interval: r_rd_data.interval,
                    deadline: new_deadline, rpt: r_rd_data.rpt};
        if (i_cmd.add_exec && !full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[IDX_W-1:0];
            wr_data = '{id: r_id_ctr, interval: r_in.period_ms,
                        deadline: r_in.now + r_in.period_ms, rpt: r_in.repeat_req};
        end else if (i_cmd.tick_step && keep) begin
            wr_en = 1'b1;
        end
    end

    // Pick the result id
    always_comb begin
        case (i_cmd.id_sel)
            ID_NEW:   sel_id = full ? 32'd0 : r_id_ctr;
            ID_ENTRY: sel_id = r_rd_data.id;
            default:  sel_id = 32'd0;
        endcase
    end

    // Entry memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[r_i[IDX_W-1:0]];
            r_rd_act  <= r_active[r_i[IDX_W-1:0]];
        end
    end

    // Latch the accepted input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end
    end

    // Table bookkeeping and scan pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_count  <= '0;
            r_id_ctr <= 32'd1;
            r_i      <= '0;
            r_w      <= '0;
        end else begin
            if (i_cmd.load_in) begin
                r_i <= '0;
                r_w <= '0;
            end
            if (i_cmd.inc_i) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.add_exec && !full) begin
                r_active[r_count[IDX_W-1:0]] <= 1'b1;
                r_count  <= r_count + 1'b1;
                r_id_ctr <= r_id_ctr + 32'd1;
            end
            if (i_cmd.clear_exec) begin
                r_active <= '0;
                r_count  <= '0;
            end
            if (i_cmd.rm_hit) begin
                r_active[r_i[IDX_W-1:0]] <= 1'b0;
            end
            if (i_cmd.tick_step) begin
                r_i <= r_i + 1'b1;
                if (keep) begin
                    r_w <= r_w + 1'b1;
                end
            end
            // Survivors now sit packed below the write pointer
            if (i_cmd.tick_end) begin
                for (int j = 0; j < MAX_TIMERS; j++) begin
                    r_active[j] <= (CNT_W'(j) < r_w);
                end
                r_count <= r_w;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_word <= '{kind: i_cmd.emit_kind, result_id: sel_id,
                            last: i_cmd.emit_last};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== rtl/deadline_timer_table.sv =====
// Top level of the deadline timer table: controller, datapath and checks.
//
// Input channel (i_in_valid / o_in_stall / i_in_word) takes one command word:
// add, remove by id, clear or tick. Output channel (o_out_valid / i_out_stall
// / o_out_word) returns result words; the final word of a command has last set.
// A word moves on a rising edge with valid high and stall low.
// Add and clear give one acknowledge word each. Remove reads the table one
// entry at a time until the id is found, then gives its acknowledge word.
// Tick reads each of the count entries through the entry memory, one at a
// time (read, then evaluate and compact in place), and gives one fired word
// per due timer and a closing done word. One command is worked on at a time;
// the next is accepted once the current one has handed its last word to the
// output register. A stalled output holds its word and pauses the scan at the
// next due entry. Reset empties the table, sets the id counter to one and
// drops any pending output word; entry memory contents are left as they are.
module deadline_timer_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  dtt_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dtt_pkg::t_out_word o_out_word
);
    import dtt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_mode  (i_in_word.mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    dtt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTH
    // Never load a word over one that is still waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted into a stalled output register");

    // Only fired words are not final
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_word.kind == KIND_FIRED) != o_out_word.last))
        else $error("last flag does not match word kind");

    // Never read past the end of the table
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd |-> !stat.scan_end)
        else $error("entry read beyond table count");
`endif

endmodule
